// File: src/ldm_pkg.sv
// Shared types, constants and helpers of the landmark drowsiness monitor.
package ldm_pkg;

	// History and counter sizes
	localparam int HISTORY_DEPTH = 10;
	localparam int SLOT_W        = 4;
	localparam int FILL_W        = 5;
	localparam int CNT_W         = 16;
	localparam int VAL_W         = 16;
	localparam int SUM_W         = VAL_W + ((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);

	// Landmark geometry
	localparam int COORD_W   = 16;
	localparam int COORD_N   = 10;
	localparam int DIST_N    = 6;
	localparam int SQ_W      = 2 * COORD_W + 2;
	localparam int RAD_W     = 48;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int DIST_W    = 21;
	localparam int ROOT_STEP = 4;
	localparam int ROOT_CYC  = ROOT_W / ROOT_STEP;
	localparam int EPS_Q8    = 32;

	// Shared divider
	localparam int NUM_W    = 36;
	localparam int DEN_W    = 24;
	localparam int DIV_STEP = 4;
	localparam int DIV_CYC  = NUM_W / DIV_STEP;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] CFG_EYE_THR    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MOUTH_THR  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_BLINK_MIN  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_BLINK_MAX  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_WARN_FRM   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_FRM  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP_FRM = 3'd6;

	// Danger grades
	localparam logic [1:0] DANGER_NONE  = 2'd0;
	localparam logic [1:0] DANGER_WARN  = 2'd1;
	localparam logic [1:0] DANGER_ALARM = 2'd2;

	localparam int IN_W  = COORD_N * COORD_W;
	localparam int OUT_W = 72;

	typedef struct packed {
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
	} pair_t;

	typedef pair_t [DIST_N-1:0] pairs_t;

	typedef struct packed {
		logic [15:0] eye_threshold;
		logic [15:0] mouth_threshold;
		logic [7:0]  blink_min_frames;
		logic [7:0]  blink_max_frames;
		logic [15:0] warning_frames;
		logic [15:0] alarm_frames;
		logic [4:0]  warmup_frames;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] yawn_total;
		logic [CNT_W-1:0] blink_total;
		logic             warming_up;
		logic [1:0]       danger_level;
		logic [VAL_W-1:0] mouth_average;
		logic [VAL_W-1:0] eye_average;
	} result_t;

	// Magnitude of the difference of two signed coordinates
	function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		logic signed [COORD_W:0] m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? -d : d;
		return m[COORD_W-1:0];
	endfunction

	// Clamp a quotient to 16 bits
	function automatic logic [VAL_W-1:0] sat16(input logic [NUM_W-1:0] q);
		return (|q[NUM_W-1:VAL_W]) ? {VAL_W{1'b1}} : q[VAL_W-1:0];
	endfunction

endpackage

// File: src/landmark_drowsiness_monitor.sv
// Top level of the landmark drowsiness monitor: configuration registers, front, queue and back.

// Each frame of five landmarks passes through the back end in steps: six distances, each
// squared in the SQX and SQY states on the single 16x16 multiplier and then rooted by the
// four-bit-a-cycle square root, then four passes through the shared divider (two ratios,
// two history means), with a fetch before and a posting of the result after. A two-entry
// queue lets the front take up to two further frames while the back works, and the result
// register lets the next frame start while a result waits.
// Configuration writes take effect at once and belong to idle periods only.
module landmark_drowsiness_monitor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// left_eye_x, left_eye_y, right_eye_x, right_eye_y, nose_x, nose_y,
	// mouth_left_x, mouth_left_y, mouth_right_x, mouth_right_y
	input  logic [ldm_pkg::IN_W-1:0]            s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// eye_average, mouth_average, danger_level, warming_up, blink_total, yawn_total
	output logic [ldm_pkg::OUT_W-1:0]           m_tdata,
	input  logic                                cfg_we,
	input  logic [ldm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [ldm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import ldm_pkg::*;

	cfg_t    cfg_q;
	pairs_t  pairs;
	pairs_t  dout;
	logic    push, full, pop, empty;
	result_t res;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eye_threshold    <= 16'd1843;
			cfg_q.mouth_threshold  <= 16'd3072;
			cfg_q.blink_min_frames <= 8'd2;
			cfg_q.blink_max_frames <= 8'd15;
			cfg_q.warning_frames   <= 16'd15;
			cfg_q.alarm_frames     <= 16'd30;
			cfg_q.warmup_frames    <= 5'd5;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_EYE_THR:    cfg_q.eye_threshold    <= cfg_wdata;
				CFG_MOUTH_THR:  cfg_q.mouth_threshold  <= cfg_wdata;
				CFG_BLINK_MIN:  cfg_q.blink_min_frames <= cfg_wdata[7:0];
				CFG_BLINK_MAX:  cfg_q.blink_max_frames <= cfg_wdata[7:0];
				CFG_WARN_FRM:   cfg_q.warning_frames   <= cfg_wdata;
				CFG_ALARM_FRM:  cfg_q.alarm_frames     <= cfg_wdata;
				CFG_WARMUP_FRM: cfg_q.warmup_frames    <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	ldm_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.full     (full),
		.push     (push),
		.pairs    (pairs)
	);

	ldm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (pairs),
		.full   (full),
		.pop    (pop),
		.dout   (dout),
		.empty  (empty)
	);

	ldm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.empty    (empty),
		.pop      (pop),
		.dout     (dout),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// Pack the result, eye_average lowest, zero-padded at the top
	assign m_tdata = {(OUT_W - $bits(result_t))'(0), res};

`ifndef SYNTHESIS
	// Danger is never graded while warming up
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.warming_up |-> res.danger_level == DANGER_NONE)
		else $error("danger graded during warm-up");

	// Danger grade stays within its three codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.danger_level != 2'd3)
		else $error("invalid danger grade");

	// The back end never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");
`endif

endmodule

// File: src/ldm_front.sv
// Front end: takes landmark transfers and forms the six coordinate difference pairs.
module ldm_front (
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [ldm_pkg::IN_W-1:0] s_tdata,
	input  logic                   full,
	output logic                   push,
	output ldm_pkg::pairs_t        pairs
);
	import ldm_pkg::*;

	logic signed [COORD_W-1:0] lex, ley, rex, rey, nx, ny, mlx, mly, mrx, mry;

	// Unpack the landmarks
	assign lex = s_tdata[0*COORD_W +: COORD_W];
	assign ley = s_tdata[1*COORD_W +: COORD_W];
	assign rex = s_tdata[2*COORD_W +: COORD_W];
	assign rey = s_tdata[3*COORD_W +: COORD_W];
	assign nx  = s_tdata[4*COORD_W +: COORD_W];
	assign ny  = s_tdata[5*COORD_W +: COORD_W];
	assign mlx = s_tdata[6*COORD_W +: COORD_W];
	assign mly = s_tdata[7*COORD_W +: COORD_W];
	assign mrx = s_tdata[8*COORD_W +: COORD_W];
	assign mry = s_tdata[9*COORD_W +: COORD_W];

	// Eye pairs first, then mouth pairs; the spacing pair closes each group
	assign pairs[0] = '{dx: abs_diff(lex, nx),  dy: abs_diff(ley, ny)};
	assign pairs[1] = '{dx: abs_diff(rex, nx),  dy: abs_diff(rey, ny)};
	assign pairs[2] = '{dx: abs_diff(rex, lex), dy: abs_diff(rey, ley)};
	assign pairs[3] = '{dx: abs_diff(mlx, nx),  dy: abs_diff(mly, ny)};
	assign pairs[4] = '{dx: abs_diff(mrx, nx),  dy: abs_diff(mry, ny)};
	assign pairs[5] = '{dx: abs_diff(mrx, mlx), dy: abs_diff(mry, mly)};

	// Take a transfer whenever the queue has room
	assign s_tready = !full;
	assign push     = s_tvalid && !full;

endmodule

// File: src/ldm_fifo.sv
// Two-entry queue of difference pairs between front and back.
module ldm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ldm_pkg::pairs_t din,
	output logic            full,
	input  logic            pop,
	output ldm_pkg::pairs_t dout,
	output logic            empty
);
	import ldm_pkg::*;

	pairs_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: src/ldm_back.sv
// Back end: distances, ratios, history means and closure tracking for one frame at a time.
module ldm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ldm_pkg::cfg_t    cfg,
	input  logic             empty,
	output logic             pop,
	input  ldm_pkg::pairs_t  dout,
	output logic             m_tvalid,
	input  logic             m_tready,
	output ldm_pkg::result_t res
);
	import ldm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam logic [1:0] JOB_EYE_R   = 2'd0;
	localparam logic [1:0] JOB_MOUTH_R = 2'd1;
	localparam logic [1:0] JOB_EYE_M   = 2'd2;
	localparam logic [1:0] JOB_MOUTH_M = 2'd3;

	logic [2:0] state_q;
	logic [2:0] k_q;
	logic [3:0] cyc_q;
	logic [1:0] job_q;

	pairs_t            entry_q;
	logic [SQ_W-1:0]   acc_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [DIST_W-1:0] dist_q [DIST_N];

	logic [NUM_W-1:0] dnum_q;
	logic [DEN_W-1:0] dden_q;
	logic [DEN_W:0]   drem_q;
	logic [NUM_W-1:0] dquo_q;

	logic [VAL_W-1:0] eye_r_q;
	logic [VAL_W-1:0] eye_avg_q;
	logic [VAL_W-1:0] mouth_avg_q;

	logic [VAL_W-1:0]  eye_hist_q   [HISTORY_DEPTH];
	logic [VAL_W-1:0]  mouth_hist_q [HISTORY_DEPTH];
	logic [SUM_W-1:0]  esum_q;
	logic [SUM_W-1:0]  msum_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic              shut_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  blink_q;
	logic [CNT_W-1:0]  yawn_q;
	logic              m_tvalid_q;
	result_t           res_q;

	logic [COORD_W-1:0]   mul_a;
	logic [2*COORD_W-1:0] prod;
	logic [ROOT_W+1:0]    rem_n;
	logic [ROOT_W-1:0]    root_n;
	logic [ROOT_W+1:0]    trial;
	logic [NUM_W-1:0]     dnum_n;
	logic [DEN_W:0]       drem_n;
	logic [NUM_W-1:0]     dquo_n;
	logic [VAL_W-1:0]     mouth_r;
	logic [SUM_W-1:0]     esum_n;
	logic [SUM_W-1:0]     msum_n;
	logic [FILL_W-1:0]    fill_n;
	logic [DIST_W:0]      eye_near, mouth_near;
	logic [DIST_W+1:0]    eye_den, mouth_den;
	logic                 out_free;
	logic                 shut_n;
	logic [CNT_W-1:0]     run_n, blink_n, yawn_n;
	logic [1:0]           danger_n;
	logic                 warming_n;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

	// Square one coordinate difference a cycle
	assign mul_a = (state_q == ST_SQX) ? entry_q[k_q].dx : entry_q[k_q].dy;
	assign prod  = mul_a * mul_a;

	// Floor square root, four result bits a cycle
	always_comb begin
		rem_n  = rem_q;
		root_n = root_q;
		trial  = '0;
		for (int i = 0; i < ROOT_STEP; i++) begin
			rem_n = {rem_n[ROOT_W-1:0], rad_q[RAD_W-1-2*i -: 2]};
			trial = {root_n, 2'b01};
			if (rem_n >= trial) begin
				rem_n  = rem_n - trial;
				root_n = {root_n[ROOT_W-2:0], 1'b1};
			end else begin
				root_n = {root_n[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Restoring division, four quotient bits a cycle
	always_comb begin
		dnum_n = dnum_q;
		drem_n = drem_q;
		dquo_n = dquo_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			drem_n = {drem_n[DEN_W-1:0], dnum_n[NUM_W-1]};
			dnum_n = {dnum_n[NUM_W-2:0], 1'b0};
			if (drem_n >= {1'b0, dden_q}) begin
				drem_n = drem_n - {1'b0, dden_q};
				dquo_n = {dquo_n[NUM_W-2:0], 1'b1};
			end else begin
				dquo_n = {dquo_n[NUM_W-2:0], 1'b0};
			end
		end
	end

	// Ratio operands and history update values
	assign eye_near   = {1'b0, dist_q[0]} + {1'b0, dist_q[1]};
	assign mouth_near = {1'b0, dist_q[3]} + {1'b0, dist_q[4]};
	assign eye_den    = {({1'b0, dist_q[2]} + (DIST_W+1)'(EPS_Q8)), 1'b0};
	assign mouth_den  = {({1'b0, dist_q[5]} + (DIST_W+1)'(EPS_Q8)), 1'b0};
	assign mouth_r    = sat16(dquo_n);
	assign esum_n     = esum_q + SUM_W'(eye_r_q) - SUM_W'(eye_hist_q[slot_q]);
	assign msum_n     = msum_q + SUM_W'(mouth_r) - SUM_W'(mouth_hist_q[slot_q]);
	assign fill_n     = (fill_q < FILL_W'(HISTORY_DEPTH)) ? fill_q + 1'b1 : fill_q;

	// Closure, blink, yawn and danger tracking for the finished frame
	always_comb begin
		shut_n    = shut_q;
		run_n     = run_q;
		blink_n   = blink_q;
		yawn_n    = yawn_q;
		danger_n  = DANGER_NONE;
		warming_n = (fill_q < cfg.warmup_frames);
		if (!warming_n) begin
			if (eye_avg_q < cfg.eye_threshold) begin
				if (!shut_q) begin
					shut_n = 1'b1;
					run_n  = CNT_W'(1);
				end else if (run_q != {CNT_W{1'b1}}) begin
					run_n = run_q + 1'b1;
				end
			end else if (shut_q) begin
				if (run_q > CNT_W'(cfg.blink_min_frames) && run_q < CNT_W'(cfg.blink_max_frames)
						&& blink_q != {CNT_W{1'b1}}) begin
					blink_n = blink_q + 1'b1;
				end
				shut_n = 1'b0;
				run_n  = '0;
			end
			if (mouth_avg_q > cfg.mouth_threshold && yawn_q != {CNT_W{1'b1}}) begin
				yawn_n = yawn_q + 1'b1;
			end
			if (run_n > cfg.alarm_frames) begin
				danger_n = DANGER_ALARM;
			end else if (run_n > cfg.warning_frames) begin
				danger_n = DANGER_WARN;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				entry_q <= dout;
			end
			ST_SQX: begin
				acc_q <= SQ_W'(prod);
			end
			ST_SQY: begin
				rad_q  <= {(RAD_W-SQ_W-8)'(0), acc_q + SQ_W'(prod), 8'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[RAD_W-2*ROOT_STEP-1:0], (2*ROOT_STEP)'(0)};
				rem_q  <= rem_n;
				root_q <= root_n;
				if (cyc_q == 4'(ROOT_CYC - 1)) begin
					dist_q[k_q] <= root_n[DIST_W-1:0];
					if (k_q == 3'(DIST_N - 1)) begin
						dnum_q <= NUM_W'({eye_near, 12'b0});
						dden_q <= DEN_W'(eye_den);
						drem_q <= '0;
					end
				end
			end
			ST_DIV: begin
				dnum_q <= dnum_n;
				drem_q <= drem_n;
				dquo_q <= dquo_n;
				if (cyc_q == 4'(DIV_CYC - 1)) begin
					drem_q <= '0;
					case (job_q)
						JOB_EYE_R: begin
							eye_r_q <= sat16(dquo_n);
							dnum_q  <= NUM_W'({mouth_near, 12'b0});
							dden_q  <= DEN_W'(mouth_den);
						end
						JOB_MOUTH_R: begin
							dnum_q <= NUM_W'(esum_n);
							dden_q <= DEN_W'(fill_n);
						end
						JOB_EYE_M: begin
							eye_avg_q <= dquo_n[VAL_W-1:0];
							dnum_q    <= NUM_W'(msum_q);
							dden_q    <= DEN_W'(fill_q);
						end
						default: begin
							mouth_avg_q <= dquo_n[VAL_W-1:0];
						end
					endcase
				end
			end
			ST_OUT: begin
				if (out_free) begin
					res_q.eye_average   <= eye_avg_q;
					res_q.mouth_average <= mouth_avg_q;
					res_q.danger_level  <= danger_n;
					res_q.warming_up    <= warming_n;
					res_q.blink_total   <= blink_n;
					res_q.yawn_total    <= yawn_n;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			cyc_q      <= '0;
			job_q      <= JOB_EYE_R;
			esum_q     <= '0;
			msum_q     <= '0;
			slot_q     <= '0;
			fill_q     <= '0;
			shut_q     <= 1'b0;
			run_q      <= '0;
			blink_q    <= '0;
			yawn_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				eye_hist_q[i]   <= '0;
				mouth_hist_q[i] <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						k_q     <= '0;
						state_q <= ST_SQX;
					end
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					cyc_q   <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cyc_q <= cyc_q + 1'b1;
					if (cyc_q == 4'(ROOT_CYC - 1)) begin
						cyc_q <= '0;
						if (k_q == 3'(DIST_N - 1)) begin
							job_q   <= JOB_EYE_R;
							state_q <= ST_DIV;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_SQX;
						end
					end
				end
				ST_DIV: begin
					cyc_q <= cyc_q + 1'b1;
					if (cyc_q == 4'(DIV_CYC - 1)) begin
						cyc_q <= '0;
						job_q <= job_q + 1'b1;
						if (job_q == JOB_MOUTH_R) begin
							// Write the new ratios into the history
							eye_hist_q[slot_q]   <= eye_r_q;
							mouth_hist_q[slot_q] <= mouth_r;
							esum_q <= esum_n;
							msum_q <= msum_n;
							fill_q <= fill_n;
							slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
						end
						if (job_q == JOB_MOUTH_M) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						shut_q     <= shut_n;
						run_q      <= run_n;
						blink_q    <= blink_n;
						yawn_q     <= yawn_n;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
